>>> rtl/pcqs_pkg.sv
// Shared types, codes and sizes of the paced command queue sender.
package pcqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    // input action codes; code 3 has no meaning
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_RX   = 2'd2;

    // command types; 5..7 have no meaning
    localparam logic [2:0] CMD_SPEED  = 3'd0;
    localparam logic [2:0] CMD_REV    = 3'd1;
    localparam logic [2:0] CMD_REVDIR = 3'd2;
    localparam logic [2:0] CMD_SWITCH = 3'd3;
    localparam logic [2:0] CMD_SENSOR = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_PUSH_OK   = 2'd0;
    localparam logic [1:0] KIND_PUSH_FULL = 2'd1;
    localparam logic [1:0] KIND_TX        = 2'd2;
    localparam logic [1:0] KIND_SENSOR    = 2'd3;

    // configuration register indexes
    localparam logic CFG_SEND_INTERVAL = 1'b0;
    localparam logic CFG_REVERSE_DELAY = 1'b1;

    localparam logic [15:0] SEND_INTERVAL_RST = 16'd10;
    localparam logic [15:0] REVERSE_DELAY_RST = 16'd3000;

    // controller byte codes
    localparam logic [7:0] BYTE_STOP     = 8'h00;
    localparam logic [7:0] BYTE_REVERSE  = 8'h0F;
    localparam logic [7:0] BYTE_STRAIGHT = 8'h21;
    localparam logic [7:0] BYTE_CURVED   = 8'h22;
    localparam logic [7:0] BYTE_SENS_A   = 8'h0C;
    localparam logic [7:0] BYTE_SENS_B   = 8'h85;
    localparam logic [3:0] SENSOR_BYTES  = 4'd10;

    typedef struct packed {
        logic [2:0] cmd_type;
        logic [7:0] arg_one;
        logic [7:0] arg_two;
    } q_entry_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] cmd_type;
        logic [7:0] arg_one;
        logic [7:0] arg_two;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [2:0]  sensor_index;
        logic [15:0] sensor_value;
        logic        sensor_done;
    } result_t;

    typedef struct packed {
        logic [1:0] count;   // 0, 1 or 2 results, r0 first
        result_t    r0;
        result_t    r1;
    } core_out_t;

endpackage

>>> rtl/pcqs_core.sv
// Command queue, pacing, deferred command and sensor collection state.
module pcqs_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                fire,
    input  pcqs_pkg::in_item_t  item,
    output pcqs_pkg::core_out_t res
);

    pcqs_pkg::q_entry_t            queue_mem [pcqs_pkg::QUEUE_DEPTH];

    logic [15:0]                   interval_reg, rev_delay_reg;
    logic [pcqs_pkg::QPTR_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [pcqs_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          def_pend_reg, def_pend_next;
    logic [15:0]                   def_args_reg, def_args_next;
    logic [31:0]                   def_due_reg, def_due_next;
    logic [31:0]                   last_reg, last_next;
    logic [31:0]                   time_reg, time_next;
    logic [3:0]                    left_reg, left_next;
    logic [7:0]                    hold_reg, hold_next;

    logic [31:0]                   time_inc, elapsed;
    logic                          do_send, pop, push_req, push_ok;
    logic [2:0]                    s_type;
    logic [7:0]                    s_a1, s_a2;
    pcqs_pkg::q_entry_t            push_entry, head_entry;
    logic [3:0]                    k;

    assign head_entry = queue_mem[head_reg];
    assign time_inc   = time_reg + 32'd1;
    assign elapsed    = time_inc - last_reg;
    assign k          = pcqs_pkg::SENSOR_BYTES - left_reg;

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        def_pend_next = def_pend_reg;
        def_args_next = def_args_reg;
        def_due_next  = def_due_reg;
        last_next     = last_reg;
        time_next     = time_reg;
        left_next     = left_reg;
        hold_next     = hold_reg;
        res           = '0;
        do_send       = 1'b0;
        pop           = 1'b0;
        push_req      = 1'b0;
        push_entry    = '0;
        s_type        = pcqs_pkg::CMD_SPEED;
        s_a1          = '0;
        s_a2          = '0;

        if (fire) begin
            unique case (item.action)
                pcqs_pkg::ACT_PUSH: begin
                    push_req   = 1'b1;
                    push_entry = '{item.cmd_type, item.arg_one, item.arg_two};
                    res.count  = 2'd1;
                    res.r0.kind = (count_reg < pcqs_pkg::QCNT_W'(pcqs_pkg::QUEUE_DEPTH))
                                ? pcqs_pkg::KIND_PUSH_OK : pcqs_pkg::KIND_PUSH_FULL;
                    res.r0.last = 1'b1;
                end
                pcqs_pkg::ACT_TICK: begin
                    time_next = time_inc;
                    if (elapsed >= {16'd0, interval_reg}) begin
                        if (def_pend_reg && (time_inc > def_due_reg)) begin
                            def_pend_next = 1'b0;
                            last_next     = time_inc;
                            do_send       = 1'b1;
                            s_type        = pcqs_pkg::CMD_REVDIR;
                            s_a1          = def_args_reg[15:8];
                            s_a2          = def_args_reg[7:0];
                        end else if (count_reg != '0) begin
                            last_next = time_inc;
                            do_send   = 1'b1;
                            pop       = 1'b1;
                            s_type    = head_entry.cmd_type;
                            s_a1      = head_entry.arg_one;
                            s_a2      = head_entry.arg_two;
                        end
                    end
                end
                pcqs_pkg::ACT_RX: begin
                    if ((left_reg != 4'd0) && (left_reg <= pcqs_pkg::SENSOR_BYTES)) begin
                        left_next = left_reg - 4'd1;
                        if (!k[0]) begin
                            hold_next = item.rx_byte;
                        end else begin
                            res.count           = 2'd1;
                            res.r0.kind         = pcqs_pkg::KIND_SENSOR;
                            res.r0.last         = 1'b1;
                            res.r0.sensor_index = k[3:1];
                            res.r0.sensor_value = {hold_reg, item.rx_byte};
                            res.r0.sensor_done  = (left_reg == 4'd1);
                        end
                    end
                end
                default: ;
            endcase
        end

        if (do_send) begin
            res.r0.kind = pcqs_pkg::KIND_TX;
            res.r1.kind = pcqs_pkg::KIND_TX;
            res.r1.last = 1'b1;
            res.r1.tx_byte = s_a1;
            res.count   = 2'd2;
            unique case (s_type)
                pcqs_pkg::CMD_SPEED: res.r0.tx_byte = s_a2;
                pcqs_pkg::CMD_REV: begin
                    res.r0.tx_byte = pcqs_pkg::BYTE_STOP;
                    def_pend_next  = 1'b1;
                    def_args_next  = {s_a1, s_a2};
                    def_due_next   = time_inc + {16'd0, rev_delay_reg};
                end
                pcqs_pkg::CMD_REVDIR: begin
                    res.r0.tx_byte = pcqs_pkg::BYTE_REVERSE;
                    push_req       = 1'b1;
                    push_entry     = '{pcqs_pkg::CMD_SPEED, s_a1, s_a2};
                end
                pcqs_pkg::CMD_SWITCH:
                    res.r0.tx_byte = (s_a2 == 8'd0) ? pcqs_pkg::BYTE_STRAIGHT
                                                    : pcqs_pkg::BYTE_CURVED;
                pcqs_pkg::CMD_SENSOR: begin
                    res.r0.tx_byte = pcqs_pkg::BYTE_SENS_A;
                    res.r1.tx_byte = pcqs_pkg::BYTE_SENS_B;
                    left_next      = pcqs_pkg::SENSOR_BYTES;
                    hold_next      = 8'd0;
                end
                default: res = '0;   // no bytes, still counts as a send
            endcase
        end

        // push is checked against the count before any pop of this cycle
        push_ok = push_req &&
                  (count_reg < pcqs_pkg::QCNT_W'(pcqs_pkg::QUEUE_DEPTH));
        if (push_ok)
            tail_next = (tail_reg == pcqs_pkg::QPTR_W'(pcqs_pkg::QUEUE_DEPTH - 1))
                      ? '0 : tail_reg + 1'b1;
        if (pop)
            head_next = (head_reg == pcqs_pkg::QPTR_W'(pcqs_pkg::QUEUE_DEPTH - 1))
                      ? '0 : head_reg + 1'b1;
        count_next = count_reg + pcqs_pkg::QCNT_W'(push_ok) - pcqs_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_ok)
            queue_mem[tail_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= pcqs_pkg::SEND_INTERVAL_RST;
            rev_delay_reg <= pcqs_pkg::REVERSE_DELAY_RST;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            def_pend_reg  <= 1'b0;
            def_args_reg  <= '0;
            def_due_reg   <= '0;
            last_reg      <= '0;
            time_reg      <= '0;
            left_reg      <= '0;
            hold_reg      <= '0;
        end else begin
            if (cfg_we && (cfg_index == pcqs_pkg::CFG_SEND_INTERVAL))
                interval_reg <= cfg_wdata;
            if (cfg_we && (cfg_index == pcqs_pkg::CFG_REVERSE_DELAY))
                rev_delay_reg <= cfg_wdata;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            def_pend_reg <= def_pend_next;
            def_args_reg <= def_args_next;
            def_due_reg  <= def_due_next;
            last_reg     <= last_next;
            time_reg     <= time_next;
            left_reg     <= left_next;
            hold_reg     <= hold_next;
        end
    end

endmodule

>>> rtl/pcqs_out_fifo.sv
// Result buffer: takes up to two results per cycle, hands out one while the receiver is ready.
module pcqs_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  pcqs_pkg::core_out_t wr,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output pcqs_pkg::result_t   out_data
);

    pcqs_pkg::result_t           mem [pcqs_pkg::OUT_DEPTH];
    logic [pcqs_pkg::OPTR_W-1:0] wp_reg, rp_reg;
    logic [pcqs_pkg::OCNT_W-1:0] cnt_reg;
    logic                        pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rp_reg];
    assign pop       = out_valid && out_ready;
    // room for a full pair regardless of this cycle's pop
    assign space     = (cnt_reg <= pcqs_pkg::OCNT_W'(pcqs_pkg::OUT_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (wr.count != 2'd0)
            mem[wp_reg] <= wr.r0;
        if (wr.count == 2'd2)
            mem[wp_reg + 1'b1] <= wr.r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + pcqs_pkg::OPTR_W'(wr.count);
            rp_reg  <= rp_reg + pcqs_pkg::OPTR_W'(pop);
            cnt_reg <= cnt_reg + pcqs_pkg::OCNT_W'(wr.count) - pcqs_pkg::OCNT_W'(pop);
        end
    end

endmodule

>>> rtl/paced_command_queue_sender.sv
// Top level of the paced command queue sender.
//
// Input stream (s_*): one transaction per push, time tick or received byte;
// tuser carries the action code, tdata the command fields and rx byte.
// Output stream (m_*): push status, transmit bytes and sensor words;
// tlast marks the second byte of a command pair and every single result.
// Configuration: cfg_we/cfg_index/cfg_wdata write send_interval (0) and
// reverse_delay (1); write only while the block is idle.
//
// An accepted transaction is held in the input register, handled once the
// result buffer has room for a pair, and its results are registered in the
// result buffer, which drives m_tvalid.
// Throughput: one transaction per cycle while each gives at most one
// result and the receiver is ready; a tick that sends a command gives two
// bytes, and the output drains one result per cycle, so such ticks slow the
// input. The limit is the single read port of the 4-entry result buffer.
// Reset clears the queue pointers, timers, sensor state and both buffers;
// the registers return to 10 and 3000. Queue contents are not cleared.
// When the receiver stalls, results collect in the result buffer; once it
// lacks room for a pair the input register holds and s_tready drops.
module paced_command_queue_sender (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cmd_type[2:0], cmd_arg_one, cmd_arg_two, rx_byte, zeros
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte, sensor_index[2:0], sensor_value, sensor_done, zeros
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last_of_run
);

    pcqs_pkg::in_item_t  in_reg;
    logic                in_v_reg;
    logic                take, space;
    pcqs_pkg::core_out_t core_res;
    pcqs_pkg::result_t   out_res;

    // handle the held transaction only when the buffer can take a pair
    assign take     = in_v_reg && space;
    assign s_tready = !in_v_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_v_reg <= 1'b1;
        end else if (take) begin
            in_v_reg <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_reg <= '{s_tuser, s_tdata[2:0], s_tdata[10:3], s_tdata[18:11],
                        s_tdata[26:19]};
    end

    pcqs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (take),
        .item      (in_reg),
        .res       (core_res)
    );

    pcqs_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (core_res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;
    assign m_tdata = {4'd0, out_res.sensor_done, out_res.sensor_value,
                      out_res.sensor_index, out_res.tx_byte};

endmodule

>>> rtl/pcqs_checker.sv
// Port-level checks of the paced command queue sender, bound to the top.
module pcqs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // nothing offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // only a transmit byte can open a run
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != pcqs_pkg::KIND_TX) |-> m_tlast)
        else $error("non-byte result without last flag");

    // sensor fields are zero unless a sensor word is shown
    a_sens_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != pcqs_pkg::KIND_SENSOR) |-> (m_tdata[27:8] == 20'd0))
        else $error("sensor fields set on other result");

    // first byte of a pair is followed, once taken, by its closing byte
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == pcqs_pkg::KIND_TX) && !m_tlast
        |=> m_tvalid && (m_tuser == pcqs_pkg::KIND_TX) && m_tlast)
        else $error("byte pair broken");

endmodule

bind paced_command_queue_sender pcqs_checker u_pcqs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
